/* rtl/core/imrp_pkg.sv */
`timescale 1ns / 1ps

package imrp_pkg;

	localparam int FRAC_BITS = 24;
	localparam int DW        = 32;
	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 32;
	// front end, root extraction, two divides, back end, output register
	localparam int NSTG = 6 + SQ_STEPS + 1 + DIV_STEPS + 1 + 5 + 1 + DIV_STEPS + 1;

	localparam logic signed [65:0] HALF  = 66'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [65:0] MAXV  = 66'sh7fff_ffff;
	localparam logic signed [65:0] MINV  = -66'sh8000_0000;
	localparam logic signed [63:0] QLIM  = 64'sd1 <<< 62;

	localparam logic [2:0] REG_P0 = 3'd0;
	localparam logic [2:0] REG_R1 = 3'd1;
	localparam logic [2:0] REG_K1 = 3'd2;
	localparam logic [2:0] REG_K2 = 3'd3;
	localparam logic [2:0] REG_K3 = 3'd4;
	localparam logic [2:0] REG_K4 = 3'd5;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sq_t;

	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] nlo;
		logic [31:0] q;
		logic [32:0] d;
		logic        ovf;
		logic        neg;
	} dv_t;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] v2;
		logic signed [31:0] root;
	} side_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > MAXV)
			return MAXV[31:0];
		if (v < MINV)
			return MINV[31:0];
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] fmul(input logic signed [31:0] x,
			input logic signed [31:0] y);
		logic signed [63:0] p;
		logic signed [65:0] t;
		p = 64'(x) * 64'(y);
		t = (66'(p) + HALF) >>> FRAC_BITS;
		return sat32(t);
	endfunction

	function automatic logic signed [31:0] fadd(input logic signed [31:0] x,
			input logic signed [31:0] y);
		return sat32(66'(x) + 66'(y));
	endfunction

	function automatic logic signed [31:0] fsub(input logic signed [31:0] x,
			input logic signed [31:0] y);
		return sat32(66'(x) - 66'(y));
	endfunction

	function automatic logic signed [31:0] fneg(input logic signed [31:0] x);
		return sat32(-66'(x));
	endfunction

	function automatic logic signed [31:0] fdbl(input logic signed [31:0] x);
		return sat32(66'(x) <<< 1);
	endfunction

	// one result bit of the integer square root
	function automatic sq_t sq_step(input sq_t x);
		logic [35:0] cat;
		logic [35:0] trial;
		sq_t y;
		cat   = {x.rem, x.rad[63:62]};
		trial = {2'b00, x.root, 2'b01};
		if (cat >= trial) begin
			y.rem  = 34'(cat - trial);
			y.root = {x.root[30:0], 1'b1};
		end else begin
			y.rem  = cat[33:0];
			y.root = {x.root[30:0], 1'b0};
		end
		y.rad = {x.rad[61:0], 2'b00};
		return y;
	endfunction

	function automatic dv_t dv_init(input logic [63:0] n, input logic [32:0] d,
			input logic neg);
		dv_t y;
		y.ovf = {1'b0, n[63:32]} >= d;
		y.rem = {1'b0, n[63:32]};
		y.nlo = n[31:0];
		y.q   = '0;
		y.d   = d;
		y.neg = neg;
		return y;
	endfunction

	// one quotient bit of the restoring divide
	function automatic dv_t dv_step(input dv_t x);
		logic [33:0] cat;
		dv_t y;
		y   = x;
		cat = {x.rem, x.nlo[31]};
		if (cat >= {1'b0, x.d}) begin
			y.rem = 33'(cat - {1'b0, x.d});
			y.q   = {x.q[30:0], 1'b1};
		end else begin
			y.rem = cat[32:0];
			y.q   = {x.q[30:0], 1'b0};
		end
		y.nlo = {x.nlo[30:0], 1'b0};
		return y;
	endfunction

	// signed, saturated quotient from magnitude and sign
	function automatic logic signed [31:0] dv_result(input dv_t x);
		if (x.neg) begin
			if (x.ovf || x.q > 32'h8000_0000)
				return MINV[31:0];
			return 32'(-x.q);
		end
		if (x.ovf || x.q[31])
			return MAXV[31:0];
		return x.q;
	endfunction

endpackage

/* rtl/core/induction_motor_reactive_power_core.sv */
`timescale 1ns / 1ps
// throughput: one request per cycle while the master side is not stalled, the whole pipeline advances together
// the root extraction and both divides take one bit per stage, which sets the depth
// a stalled result holds every stage, nothing is dropped or repeated
// reset clears all valid bits and the six configuration registers to zero
module induction_motor_reactive_power_core
	import imrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // terminal_voltage
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // reactive_power
	output logic        m_tuser    // solved
);

	logic signed [31:0] p0_q, r1_q, k1_q, k2_q, k3_q, k4_q;
	logic [2:0]         ridx;
	logic               en;
	logic [NSTG-1:0]    vld_q;

	assign pready = 1'b1;
	assign ridx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0_q <= '0;
			r1_q <= '0;
			k1_q <= '0;
			k2_q <= '0;
			k3_q <= '0;
			k4_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_P0: p0_q <= pwdata;
				REG_R1: r1_q <= pwdata;
				REG_K1: k1_q <= pwdata;
				REG_K2: k2_q <= pwdata;
				REG_K3: k3_q <= pwdata;
				REG_K4: k4_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_P0: prdata = p0_q;
			REG_R1: prdata = r1_q;
			REG_K1: prdata = k1_q;
			REG_K2: prdata = k2_q;
			REG_K3: prdata = k3_q;
			REG_K4: prdata = k4_q;
			default: prdata = '0;
		endcase
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[NSTG-2:0], s_tvalid};
	end

	// coefficient front end
	logic signed [31:0] v2_s1, rr_s1, k33_s1, rk2_s1, k34_s1, k13_s1, k22_s1, k44_s1;
	logic signed [31:0] v2_s2, sa_s2, sb_s2, sc_s2, sd_s2, v2r1_s2, v2k1_s2;
	logic signed [31:0] v2_s3, pa_s3, pb_s3, vc_s3, pd_s3, vk_s3, v2r1_s3;
	logic signed [31:0] v2_s4, a_s4, b_s4, c_s4;
	logic signed [31:0] v2_s5, a_s5, b_s5;
	logic signed [63:0] bsq_s5, ac_s5;
	logic signed [63:0] quarter;
	side_t              sd_s6;
	logic [63:0]        disc_s6;

	assign quarter = $signed({2'b00, bsq_s5[63:2]}) - ac_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			v2_s1  <= fmul(s_tdata, s_tdata);
			rr_s1  <= fmul(r1_q, r1_q);
			k33_s1 <= fmul(k3_q, k3_q);
			rk2_s1 <= fmul(r1_q, k2_q);
			k34_s1 <= fmul(k3_q, k4_q);
			k13_s1 <= fmul(k1_q, k3_q);
			k22_s1 <= fmul(k2_q, k2_q);
			k44_s1 <= fmul(k4_q, k4_q);

			v2_s2   <= v2_s1;
			sa_s2   <= fadd(rr_s1, k33_s1);
			sb_s2   <= fadd(rk2_s1, k34_s1);
			sc_s2   <= fadd(k2_q, k13_s1);
			sd_s2   <= fadd(k22_s1, k44_s1);
			v2r1_s2 <= fmul(v2_s1, r1_q);
			v2k1_s2 <= fmul(v2_s1, k1_q);

			v2_s3   <= v2_s2;
			pa_s3   <= fmul(p0_q, sa_s2);
			pb_s3   <= fmul(p0_q, sb_s2);
			vc_s3   <= fmul(v2_s2, sc_s2);
			pd_s3   <= fmul(p0_q, sd_s2);
			vk_s3   <= fmul(v2k1_s2, k4_q);
			v2r1_s3 <= v2r1_s2;

			v2_s4 <= v2_s3;
			a_s4  <= fsub(pa_s3, v2r1_s3);
			b_s4  <= fsub(fdbl(pb_s3), vc_s3);
			c_s4  <= fsub(pd_s3, vk_s3);

			v2_s5  <= v2_s4;
			a_s5   <= a_s4;
			b_s5   <= b_s4;
			bsq_s5 <= 64'(b_s4) * 64'(b_s4);
			ac_s5  <= 64'(a_s4) * 64'(c_s4);

			sd_s6.ok   <= !quarter[63] && (a_s5 != '0);
			sd_s6.a    <= a_s5;
			sd_s6.b    <= b_s5;
			sd_s6.v2   <= v2_s5;
			sd_s6.root <= '0;
			if (quarter >= QLIM)
				disc_s6 <= '1;
			else
				disc_s6 <= {quarter[61:0], bsq_s5[1:0]};
		end
	end

	// integer square root, one bit per stage
	sq_t   sq_s [1:SQ_STEPS];
	side_t sqd_s[1:SQ_STEPS];

	for (genvar i = 1; i <= SQ_STEPS; i++) begin : g_sq
		if (i == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					sq_s[i]  <= sq_step('{rem: '0, root: '0, rad: disc_s6});
					sqd_s[i] <= sd_s6;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					sq_s[i]  <= sq_step(sq_s[i-1]);
					sqd_s[i] <= sqd_s[i-1];
				end
			end
		end
	end

	// root = (-b + s) / (2a)
	logic signed [33:0] rnum;
	logic [33:0]        rmag;
	logic signed [32:0] twoa;
	logic [32:0]        amag;

	assign rnum = 34'({2'b00, sq_s[SQ_STEPS].root}) - 34'(sqd_s[SQ_STEPS].b);
	assign rmag = rnum[33] ? 34'(-rnum) : rnum;
	assign twoa = {sqd_s[SQ_STEPS].a, 1'b0};
	assign amag = twoa[32] ? 33'(-twoa) : twoa;

	dv_t   d1_s [0:DIV_STEPS];
	side_t d1d_s[0:DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s[0]  <= dv_init(64'(rmag) << FRAC_BITS, amag,
				rnum[33] ^ sqd_s[SQ_STEPS].a[31]);
			d1d_s[0] <= sqd_s[SQ_STEPS];
		end
	end

	for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_d1
		always_ff @(posedge clk) begin
			if (en) begin
				d1_s[i]  <= dv_step(d1_s[i-1]);
				d1d_s[i] <= d1d_s[i-1];
			end
		end
	end

	// reactive power back end
	side_t              rt_d;
	side_t              rt_s, t1_s, t2_s, t3_s, t4_s, t5_s;
	logic signed [31:0] rr1_t1, rk3_t1;
	logic signed [31:0] qc_t2, qd_t2;
	logic signed [31:0] qa_t3, qb_t3, cc_t3, dd_t3;
	logic signed [31:0] diff_t4, den_t4;
	logic signed [31:0] num_t5, den_t5;

	always_comb begin
		rt_d      = d1d_s[DIV_STEPS];
		rt_d.root = dv_result(d1_s[DIV_STEPS]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_s <= rt_d;

			t1_s   <= rt_s;
			rr1_t1 <= fmul(rt_s.root, r1_q);
			rk3_t1 <= fmul(rt_s.root, k3_q);

			t2_s  <= t1_s;
			qc_t2 <= fadd(rr1_t1, k2_q);
			qd_t2 <= fadd(rk3_t1, k4_q);

			t3_s  <= t2_s;
			qa_t3 <= fmul(k1_q, qc_t2);
			qb_t3 <= fmul(t2_s.root, qd_t2);
			cc_t3 <= fmul(qc_t2, qc_t2);
			dd_t3 <= fmul(qd_t2, qd_t2);

			t4_s    <= t3_s;
			diff_t4 <= fsub(qa_t3, qb_t3);
			den_t4  <= fadd(cc_t3, dd_t3);

			t5_s   <= t4_s;
			num_t5 <= fmul(fneg(t4_s.v2), diff_t4);
			den_t5 <= den_t4;
		end
	end

	// q = num / den
	logic [32:0] nmag, dmag;
	side_t       d2_d;

	assign nmag = num_t5[31] ? 33'(-34'(num_t5)) : 33'(num_t5);
	assign dmag = den_t5[31] ? 33'(-34'(den_t5)) : 33'(den_t5);

	always_comb begin
		d2_d    = t5_s;
		d2_d.ok = t5_s.ok && (den_t5 != '0);
	end

	dv_t   d2_s [0:DIV_STEPS];
	side_t d2d_s[0:DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s[0]  <= dv_init(64'(nmag) << FRAC_BITS, dmag, num_t5[31] ^ den_t5[31]);
			d2d_s[0] <= d2_d;
		end
	end

	for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_d2
		always_ff @(posedge clk) begin
			if (en) begin
				d2_s[i]  <= dv_step(d2_s[i-1]);
				d2d_s[i] <= d2d_s[i-1];
			end
		end
	end

	logic [31:0] res_q;
	logic        ok_q;

	always_ff @(posedge clk) begin
		if (en) begin
			ok_q  <= d2d_s[DIV_STEPS].ok;
			res_q <= d2d_s[DIV_STEPS].ok ? dv_result(d2_s[DIV_STEPS]) : '0;
		end
	end

	assign m_tdata = res_q;
	assign m_tuser = ok_q;

endmodule
